@@ sv/pmm_pkg.sv @@
// ----------------------------------------------------------------------------
// pmm_pkg
// Types, port codes and tables for the paged memory mapper and I/O ports.
// ----------------------------------------------------------------------------
package pmm_pkg;

  // Bus cycle kinds; codes five to seven are unused and change no register
  typedef enum logic [2:0] {
    KIND_MEM_RD = 3'd0,
    KIND_MEM_WR = 3'd1,
    KIND_IO_RD  = 3'd2,
    KIND_IO_WR  = 3'd3,
    KIND_TICK   = 3'd4
  } kind_t;

  // Target devices of a memory access
  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_URAM = 3'd1,
    TGT_VRAM = 3'd2,
    TGT_SROM = 3'd3,
    TGT_XROM = 3'd4,
    TGT_CART = 3'd5
  } target_t;

  // Geometry and defaults
  localparam int KEY_ROWS           = 10;
  localparam int CRTC_REG_COUNT_DEF = 18;
  localparam int CRTC_SEL_W         = 5;
  localparam int CRTC_WR_LIMIT      = 16;
  localparam int CRTC_RD_LOW        = 12;
  localparam int CRTC_RD_HIGH       = 17;

  // Physical bases of user RAM windows
  localparam logic [15:0] URAM_BASE_1 = 16'h4000;
  localparam logic [15:0] URAM_BASE_2 = 16'h8000;
  localparam logic [15:0] URAM_BASE_3 = 16'hC000;

  // I/O port codes (low byte of the address)
  localparam logic [7:0] PORT_BORDER    = 8'h00;
  localparam logic [7:0] PORT_PAGING    = 8'h02;
  localparam logic [7:0] PORT_KEY_ROW   = 8'h03;
  localparam logic [7:0] PORT_IRQ_EN    = 8'h05;
  localparam logic [7:0] PORT_MODE      = 8'h06;
  localparam logic [7:0] PORT_IRQ_ACK   = 8'h07;
  localparam logic [7:0] PORT_VBANK_0   = 8'h0C;
  localparam logic [7:0] PORT_VBANK_1   = 8'h0D;
  localparam logic [7:0] PORT_VBANK_2   = 8'h0E;
  localparam logic [7:0] PORT_VBANK_3   = 8'h0F;
  localparam logic [7:0] PORT_KBD_0     = 8'h58;
  localparam logic [7:0] PORT_KBD_1     = 8'h5C;
  localparam logic [7:0] PORT_IRQ_ST_0  = 8'h59;
  localparam logic [7:0] PORT_IRQ_ST_1  = 8'h5D;
  localparam logic [7:0] PORT_CRTC_SEL  = 8'h70;
  localparam logic [7:0] PORT_CRTC_DATA = 8'h71;
  localparam logic [3:0] PORT_HI_PAL    = 4'h6;
  localparam logic [3:0] PORT_HI_CRTC   = 4'h7;

  // Read-back bytes
  localparam logic [7:0] IO_IDLE    = 8'hFF;
  localparam logic [7:0] IRQ_ST_SET = 8'hEF;

  // Result of one item held between the front stage and the output register
  typedef struct packed {
    target_t     target;
    logic [15:0] mem_offset;
    logic        mem_write;
    logic [7:0]  io_data;
    logic        use_crtc;
    logic        irq_active;
    logic [3:0]  key_row;
  } stage_t;

  // Colour index from bits 0, 2, 4 and 6 of a byte
  function automatic logic [3:0] colour_index(input logic [7:0] c);
    return {c[6], c[4], c[2], c[0]};
  endfunction

  // Write masks of the CRTC registers
  function automatic logic [7:0] crtc_mask(input logic [3:0] idx);
    logic [7:0] m;
    case (idx)
      4'd4, 4'd6, 4'd7, 4'd10: m = 8'h7F;
      4'd5, 4'd9, 4'd11:       m = 8'h1F;
      4'd12, 4'd14:            m = 8'h3F;
      default:                 m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

@@ sv/paged_memory_mapper_io_ports.sv @@
// ----------------------------------------------------------------------------
// paged_memory_mapper_io_ports
// System controller: maps CPU memory accesses through the paging port,
// decodes I/O reads and writes, keeps the interrupt flag and the CRTC file.
// ----------------------------------------------------------------------------
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_stall, kind, address, data,        | to block
//          | keyboard_data                                   |
//  out     | out_valid, out_stall, target, mem_offset,       | from block
//          | mem_write, io_data, irq_active, key_row_out     |
//
//  One item per cycle is accepted while in_stall is low; each result passes
//  the front stage, which registers the CRTC read, then the output register.
//  Controller registers update at acceptance; the CRTC memory is written at
//  acceptance and read in the same edge, so items in flight never collide.
//  Reset clears the controller registers, valid flags and CRTC valid bits.
//  A stall on the output holds the output register, then the front stage,
//  then the input.
module paged_memory_mapper_io_ports #(
  parameter int CRTC_REG_COUNT = pmm_pkg::CRTC_REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  input  logic [7:0]  keyboard_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  target,
  output logic [15:0] mem_offset,
  output logic        mem_write,
  output logic [7:0]  io_data,
  output logic        irq_active,
  output logic [3:0]  key_row_out
);

  localparam int IDX_W = $clog2(CRTC_REG_COUNT);

  // Controller registers
  logic [7:0] paging_byte, paging_byte_next;
  logic [1:0] cpu_video_bank, cpu_video_bank_next;
  logic [1:0] crtc_video_bank, crtc_video_bank_next;
  logic [3:0] key_row, key_row_next;
  logic [1:0] display_mode, display_mode_next;
  logic       irq_flag, irq_flag_next;
  logic       tick_irq_enable, tick_irq_enable_next;
  logic [3:0] border_index, border_index_next;
  logic [3:0] palette_indices [4];
  logic [3:0] palette_next;
  logic       palette_we;
  logic [pmm_pkg::CRTC_SEL_W-1:0] crtc_select, crtc_select_next;

  // CRTC register memory
  logic [7:0]                crtc_file [CRTC_REG_COUNT];
  logic [CRTC_REG_COUNT-1:0] crtc_written;
  logic [7:0]                crtc_rdata;
  logic                      crtc_rvalid;
  logic                      crtc_we;
  logic                      crtc_re;
  logic [7:0]                crtc_wdata;
  logic [IDX_W-1:0]          crtc_idx;

  // Pipeline
  logic            accept;
  logic            s1_valid;
  logic            s1_adv;
  pmm_pkg::stage_t s1, s1_next;
  pmm_pkg::target_t map_tgt;
  logic [15:0]     map_ofs;
  logic [13:0]     off;
  logic [7:0]      port;
  logic [7:0]      io_out;

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  assign off      = address[13:0];
  assign port     = address[7:0];
  assign crtc_idx = crtc_select[IDX_W-1:0];

  // Map the address through the page selects
  always_comb begin
    map_tgt = pmm_pkg::TGT_NONE;
    map_ofs = {2'b00, off};
    unique case (address[15:14])
      2'd0: begin
        unique case (paging_byte[4:3])
          2'd0: map_tgt = pmm_pkg::TGT_SROM;
          2'd1: map_tgt = pmm_pkg::TGT_CART;
          2'd2: map_tgt = pmm_pkg::TGT_URAM;
          default: begin
            map_tgt = pmm_pkg::TGT_URAM;
            map_ofs = pmm_pkg::URAM_BASE_3 | {2'b00, off};
          end
        endcase
      end
      2'd1: begin
        if (paging_byte[2]) begin
          map_tgt = pmm_pkg::TGT_VRAM;
          map_ofs = {cpu_video_bank, off};
        end else begin
          map_tgt = pmm_pkg::TGT_URAM;
          map_ofs = pmm_pkg::URAM_BASE_1 | {2'b00, off};
        end
      end
      2'd2: begin
        if (paging_byte[5]) begin
          map_tgt = pmm_pkg::TGT_URAM;
          map_ofs = pmm_pkg::URAM_BASE_2 | {2'b00, off};
        end else begin
          map_tgt = pmm_pkg::TGT_VRAM;
          map_ofs = {cpu_video_bank, off};
        end
      end
      default: begin
        unique case (paging_byte[7:6])
          2'd0: map_tgt = pmm_pkg::TGT_CART;
          2'd1: map_tgt = pmm_pkg::TGT_SROM;
          2'd2: begin
            map_tgt = pmm_pkg::TGT_URAM;
            map_ofs = pmm_pkg::URAM_BASE_3 | {2'b00, off};
          end
          default: map_tgt = pmm_pkg::TGT_XROM;
        endcase
      end
    endcase
  end

  // Decode the item: result fields and next register values
  always_comb begin
    paging_byte_next     = paging_byte;
    cpu_video_bank_next  = cpu_video_bank;
    crtc_video_bank_next = crtc_video_bank;
    key_row_next         = key_row;
    display_mode_next    = display_mode;
    irq_flag_next        = irq_flag;
    tick_irq_enable_next = tick_irq_enable;
    border_index_next    = border_index;
    crtc_select_next     = crtc_select;
    palette_we           = 1'b0;
    palette_next         = pmm_pkg::colour_index(data);
    crtc_we              = 1'b0;
    crtc_wdata           = data & pmm_pkg::crtc_mask(crtc_select[3:0]);

    s1_next.target     = pmm_pkg::TGT_NONE;
    s1_next.mem_offset = '0;
    s1_next.mem_write  = 1'b0;
    s1_next.io_data    = pmm_pkg::IO_IDLE;
    s1_next.use_crtc   = 1'b0;

    case (kind)
      pmm_pkg::KIND_MEM_RD: begin
        s1_next.target     = map_tgt;
        s1_next.mem_offset = map_ofs;
      end
      pmm_pkg::KIND_MEM_WR: begin
        s1_next.target     = map_tgt;
        s1_next.mem_offset = map_ofs;
        s1_next.mem_write  = (map_tgt != pmm_pkg::TGT_SROM) &&
                             (map_tgt != pmm_pkg::TGT_XROM);
      end
      pmm_pkg::KIND_IO_RD: begin
        unique case (port) inside
          pmm_pkg::PORT_KBD_0, pmm_pkg::PORT_KBD_1: begin
            if ({1'b0, key_row} < 5'(pmm_pkg::KEY_ROWS)) begin
              s1_next.io_data = keyboard_data;
            end
          end
          pmm_pkg::PORT_IRQ_ST_0, pmm_pkg::PORT_IRQ_ST_1: begin
            s1_next.io_data = irq_flag ? pmm_pkg::IRQ_ST_SET : pmm_pkg::IO_IDLE;
          end
          pmm_pkg::PORT_CRTC_SEL: begin
            s1_next.io_data = {3'b000, crtc_select};
          end
          pmm_pkg::PORT_CRTC_DATA: begin
            s1_next.use_crtc =
              ({1'b0, crtc_select} >= 6'(pmm_pkg::CRTC_RD_LOW)) &&
              ({1'b0, crtc_select} <= 6'(pmm_pkg::CRTC_RD_HIGH)) &&
              ({1'b0, crtc_select} < 6'(CRTC_REG_COUNT));
          end
          default: ;
        endcase
      end
      pmm_pkg::KIND_IO_WR: begin
        if (port[7:4] == pmm_pkg::PORT_HI_PAL) begin
          palette_we = 1'b1;
        end else if (port[7:4] == pmm_pkg::PORT_HI_CRTC) begin
          if (!port[0]) begin
            crtc_select_next = data[pmm_pkg::CRTC_SEL_W-1:0];
          end else begin
            crtc_we = ({1'b0, crtc_select} < 6'(pmm_pkg::CRTC_WR_LIMIT)) &&
                      ({1'b0, crtc_select} < 6'(CRTC_REG_COUNT));
          end
        end else begin
          unique case (port) inside
            pmm_pkg::PORT_BORDER:  border_index_next = pmm_pkg::colour_index({1'b0, data[7:1]});
            pmm_pkg::PORT_PAGING:  paging_byte_next = data;
            pmm_pkg::PORT_KEY_ROW: key_row_next = data[3:0];
            pmm_pkg::PORT_IRQ_EN:  tick_irq_enable_next = data[4];
            pmm_pkg::PORT_MODE:    display_mode_next = (data[1:0] == 2'd3) ? 2'd2 : data[1:0];
            pmm_pkg::PORT_IRQ_ACK: irq_flag_next = 1'b0;
            pmm_pkg::PORT_VBANK_0, pmm_pkg::PORT_VBANK_1,
            pmm_pkg::PORT_VBANK_2, pmm_pkg::PORT_VBANK_3: begin
              crtc_video_bank_next = data[5:4];
              cpu_video_bank_next  = data[1:0];
            end
            default: ;
          endcase
        end
      end
      pmm_pkg::KIND_TICK: begin
        if (tick_irq_enable) begin
          irq_flag_next = 1'b1;
        end
      end
      default: ;
    endcase

    crtc_re            = s1_next.use_crtc;
    s1_next.irq_active = irq_flag_next;
    s1_next.key_row    = key_row_next;
  end

  // Hold controller registers; update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      paging_byte     <= '0;
      cpu_video_bank  <= '0;
      crtc_video_bank <= '0;
      key_row         <= '0;
      display_mode    <= '0;
      irq_flag        <= 1'b0;
      tick_irq_enable <= 1'b0;
      border_index    <= '0;
      crtc_select     <= '0;
      for (int i = 0; i < 4; i++) begin
        palette_indices[i] <= '0;
      end
    end else if (accept) begin
      paging_byte     <= paging_byte_next;
      cpu_video_bank  <= cpu_video_bank_next;
      crtc_video_bank <= crtc_video_bank_next;
      key_row         <= key_row_next;
      display_mode    <= display_mode_next;
      irq_flag        <= irq_flag_next;
      tick_irq_enable <= tick_irq_enable_next;
      border_index    <= border_index_next;
      crtc_select     <= crtc_select_next;
      if (palette_we) begin
        palette_indices[port[1:0]] <= palette_next;
      end
    end
  end

  // CRTC memory: write and registered read on acceptance
  always_ff @(posedge clk) begin
    if (accept && crtc_we) begin
      crtc_file[crtc_idx] <= crtc_wdata;
    end
    if (accept && crtc_re) begin
      crtc_rdata  <= crtc_file[crtc_idx];
      crtc_rvalid <= crtc_written[crtc_idx];
    end
  end

  // Mark CRTC entries once written; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      crtc_written <= '0;
    end else if (accept && crtc_we) begin
      crtc_written[crtc_idx] <= 1'b1;
    end
  end

  // Advance the front stage; fill it whenever an item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  // Merge the CRTC read data into the result
  assign io_out = s1.use_crtc ? (crtc_rvalid ? crtc_rdata : 8'h00) : s1.io_data;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      target      <= s1.target;
      mem_offset  <= s1.mem_offset;
      mem_write   <= s1.mem_write;
      io_data     <= io_out;
      irq_active  <= s1.irq_active;
      key_row_out <= s1.key_row;
    end
  end

endmodule

@@ bench/tb_paged_memory_mapper_io_ports.sv @@
// ----------------------------------------------------------------------------
// tb_paged_memory_mapper_io_ports
// Self-checking bench for the paged memory mapper and I/O port controller.
// A directed table covers reset values, the edges of the memory map,
// suppressed ROM writes, the interrupt path, the keyboard row limit and the
// CRTC select and data ports. A long random run of bus accesses, port
// sequences, ticks and noise follows. Every result is checked against a
// typed expectation or a behavioural model of the controller, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_paged_memory_mapper_io_ports;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_ITEMS = 1300;
  localparam int          CRTC_REGS    = pmm_pkg::CRTC_REG_COUNT_DEF;
  localparam logic [2:0]  KIND_SPARE   = 3'd7;
  localparam logic [0:15][7:0] CRTC_WMASK = {
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h1F, 8'h7F, 8'h7F,
    8'hFF, 8'h1F, 8'h7F, 8'h1F, 8'h3F, 8'hFF, 8'h3F, 8'hFF
  };

  // One result of the controller
  typedef struct packed {
    pmm_pkg::target_t target;
    logic [15:0]      mem_offset;
    logic             mem_write;
    logic [7:0]       io_data;
    logic             irq_active;
    logic [3:0]       key_row;
  } result_t;

  // One row of the directed table
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  kbd;
    logic        typed;
    result_t     want;
  } bus_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  kind;
  logic [15:0] address;
  logic [7:0]  data;
  logic [7:0]  keyboard_data;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  target;
  logic [15:0] mem_offset;
  logic        mem_write;
  logic [7:0]  io_data;
  logic        irq_active;
  logic [3:0]  key_row_out;

  // Typed expectation travelling with the item on the input port
  logic        fixed_on;
  result_t     fixed_result;

  result_t     pending_results[$];
  bus_row_t    directed_rows[$];
  int          mismatches;
  int          items_offered;
  int          send_mode;
  int          recv_mode;

  // Model copy of the controller registers
  logic [7:0]  page_sel;
  logic [1:0]  vram_cpu_bank;
  logic [1:0]  vram_crtc_bank;
  logic [3:0]  kbd_row;
  logic [1:0]  disp_mode;
  logic        irq_pending;
  logic        tick_irq_en;
  logic [3:0]  border_col;
  logic [3:0]  pal_col [4];
  logic [4:0]  crtc_sel;
  logic [7:0]  crtc_regs [CRTC_REGS];

  paged_memory_mapper_io_ports dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .address      (address),
    .data         (data),
    .keyboard_data(keyboard_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .target       (target),
    .mem_offset   (mem_offset),
    .mem_write    (mem_write),
    .io_data      (io_data),
    .irq_active   (irq_active),
    .key_row_out  (key_row_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // Gather bits 0, 2, 4 and 6 into a colour index
  function automatic logic [3:0] even_bits(input logic [7:0] c);
    logic [3:0] r;
    for (int b = 0; b < 4; b++) r[b] = c[2 * b];
    return r;
  endfunction

  // Idle length for one item: none, any, or now and then
  function automatic int idle_cycles(input int mode);
    int n;
    case (mode)
      0:       n = 0;
      1:       n = $urandom_range(0, 15);
      default: n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    endcase
    return n;
  endfunction

  function automatic bus_row_t open_row(input logic [2:0] k, input logic [15:0] a,
                                        input logic [7:0] d, input logic [7:0] kb);
    bus_row_t r;
    r = '0;
    r.kind    = k;
    r.address = a;
    r.data    = d;
    r.kbd     = kb;
    return r;
  endfunction

  function automatic bus_row_t typed_row(input logic [2:0] k, input logic [15:0] a,
                                         input logic [7:0] d, input logic [7:0] kb,
                                         input pmm_pkg::target_t t, input logic [15:0] o,
                                         input logic w, input logic [7:0] io,
                                         input logic irq, input logic [3:0] row);
    bus_row_t r;
    r = open_row(k, a, d, kb);
    r.typed           = 1'b1;
    r.want.target     = t;
    r.want.mem_offset = o;
    r.want.mem_write  = w;
    r.want.io_data    = io;
    r.want.irq_active = irq;
    r.want.key_row    = row;
    return r;
  endfunction

  // Work out the result of one access and advance the register copy
  function automatic result_t advance_controller(input logic [2:0] k, input logic [15:0] a,
                                                 input logic [7:0] d, input logic [7:0] kb);
    result_t     r;
    logic [7:0]  port;
    logic [15:0] off;
    logic [15:0] vofs;
    r         = '0;
    r.io_data = pmm_pkg::IO_IDLE;
    port      = a[7:0];
    off       = {2'b00, a[13:0]};
    vofs      = {vram_cpu_bank, a[13:0]};
    case (k)
      pmm_pkg::KIND_MEM_RD, pmm_pkg::KIND_MEM_WR: begin
        // map the 16K page through the paging byte
        case (a[15:14])
          2'd0: begin
            case (page_sel[4:3])
              2'd0:    begin r.target = pmm_pkg::TGT_SROM; r.mem_offset = off; end
              2'd1:    begin r.target = pmm_pkg::TGT_CART; r.mem_offset = off; end
              2'd2:    begin r.target = pmm_pkg::TGT_URAM; r.mem_offset = off; end
              default: begin
                r.target     = pmm_pkg::TGT_URAM;
                r.mem_offset = pmm_pkg::URAM_BASE_3 | off;
              end
            endcase
          end
          2'd1: begin
            if (page_sel[2]) begin
              r.target = pmm_pkg::TGT_VRAM; r.mem_offset = vofs;
            end else begin
              r.target = pmm_pkg::TGT_URAM; r.mem_offset = pmm_pkg::URAM_BASE_1 | off;
            end
          end
          2'd2: begin
            if (page_sel[5]) begin
              r.target = pmm_pkg::TGT_URAM; r.mem_offset = pmm_pkg::URAM_BASE_2 | off;
            end else begin
              r.target = pmm_pkg::TGT_VRAM; r.mem_offset = vofs;
            end
          end
          default: begin
            case (page_sel[7:6])
              2'd0:    begin r.target = pmm_pkg::TGT_CART; r.mem_offset = off; end
              2'd1:    begin r.target = pmm_pkg::TGT_SROM; r.mem_offset = off; end
              2'd2:    begin
                r.target     = pmm_pkg::TGT_URAM;
                r.mem_offset = pmm_pkg::URAM_BASE_3 | off;
              end
              default: begin r.target = pmm_pkg::TGT_XROM; r.mem_offset = off; end
            endcase
          end
        endcase
        // drop writes that land on ROM
        r.mem_write = (k == pmm_pkg::KIND_MEM_WR) && (r.target != pmm_pkg::TGT_SROM) &&
                      (r.target != pmm_pkg::TGT_XROM);
      end
      pmm_pkg::KIND_IO_RD: begin
        case (port)
          pmm_pkg::PORT_KBD_0, pmm_pkg::PORT_KBD_1:
            r.io_data = (kbd_row < pmm_pkg::KEY_ROWS) ? kb : pmm_pkg::IO_IDLE;
          pmm_pkg::PORT_IRQ_ST_0, pmm_pkg::PORT_IRQ_ST_1:
            r.io_data = irq_pending ? pmm_pkg::IRQ_ST_SET : pmm_pkg::IO_IDLE;
          pmm_pkg::PORT_CRTC_SEL:
            r.io_data = {3'b000, crtc_sel};
          pmm_pkg::PORT_CRTC_DATA: begin
            if (crtc_sel >= pmm_pkg::CRTC_RD_LOW && crtc_sel <= pmm_pkg::CRTC_RD_HIGH &&
                crtc_sel < CRTC_REGS)
              r.io_data = crtc_regs[crtc_sel];
          end
          default: ;
        endcase
      end
      pmm_pkg::KIND_IO_WR: begin
        if (port[7:4] == pmm_pkg::PORT_HI_PAL) begin
          pal_col[port[1:0]] = even_bits(d);
        end else if (port[7:4] == pmm_pkg::PORT_HI_CRTC) begin
          // even ports select, odd ports write through the mask
          if (!port[0])
            crtc_sel = d[4:0];
          else if (crtc_sel < pmm_pkg::CRTC_WR_LIMIT && crtc_sel < CRTC_REGS)
            crtc_regs[crtc_sel] = d & CRTC_WMASK[crtc_sel[3:0]];
        end else begin
          case (port)
            pmm_pkg::PORT_BORDER:  border_col = even_bits({1'b0, d[7:1]});
            pmm_pkg::PORT_PAGING:  page_sel = d;
            pmm_pkg::PORT_KEY_ROW: kbd_row = d[3:0];
            pmm_pkg::PORT_IRQ_EN:  tick_irq_en = d[4];
            pmm_pkg::PORT_MODE:    disp_mode = (d[1:0] == 2'd3) ? 2'd2 : d[1:0];
            pmm_pkg::PORT_IRQ_ACK: irq_pending = 1'b0;
            pmm_pkg::PORT_VBANK_0, pmm_pkg::PORT_VBANK_1,
            pmm_pkg::PORT_VBANK_2, pmm_pkg::PORT_VBANK_3: begin
              vram_crtc_bank = d[5:4];
              vram_cpu_bank  = d[1:0];
            end
            default: ;
          endcase
        end
      end
      pmm_pkg::KIND_TICK: if (tick_irq_en) irq_pending = 1'b1;
      default: ;
    endcase
    r.irq_active = irq_pending;
    r.key_row    = kbd_row;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // Present one item and hold it until it is taken
  task automatic offer_item(input logic [2:0] k, input logic [15:0] a, input logic [7:0] d,
                            input logic [7:0] kb, input logic typed, input result_t want);
    int gap;
    if (items_offered % 50 == 0) send_mode = $urandom_range(0, 2);
    gap = idle_cycles(send_mode);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    address       <= a;
    data          <= d;
    keyboard_data <= kb;
    fixed_on      <= typed;
    fixed_result  <= want;
    do @(posedge clk); while (in_stall);
    items_offered++;
    @(negedge clk);
  endtask

  // Port with a well-known meaning, now and then any byte
  function automatic logic [7:0] some_port();
    logic [7:0] p;
    case ($urandom_range(0, 16))
      0:       p = pmm_pkg::PORT_BORDER;
      1, 2:    p = pmm_pkg::PORT_PAGING;
      3:       p = pmm_pkg::PORT_KEY_ROW;
      4:       p = pmm_pkg::PORT_IRQ_EN;
      5:       p = pmm_pkg::PORT_MODE;
      6:       p = pmm_pkg::PORT_IRQ_ACK;
      7:       p = 8'(pmm_pkg::PORT_VBANK_0 + $urandom_range(0, 3));
      8:       p = {pmm_pkg::PORT_HI_PAL, 4'($urandom_range(0, 15))};
      9:       p = {pmm_pkg::PORT_HI_CRTC, 4'($urandom_range(0, 15))};
      10:      p = pmm_pkg::PORT_KBD_0;
      11:      p = pmm_pkg::PORT_KBD_1;
      12:      p = pmm_pkg::PORT_IRQ_ST_0;
      13:      p = pmm_pkg::PORT_IRQ_ST_1;
      14:      p = pmm_pkg::PORT_CRTC_SEL;
      15:      p = pmm_pkg::PORT_CRTC_DATA;
      default: p = 8'($urandom);
    endcase
    return p;
  endfunction

  // Result receiver with its own idling
  initial begin : receiver
    int gap;
    int taken;
    taken     = 0;
    out_stall = 1'b0;
    forever begin
      if (taken % 50 == 0) recv_mode = $urandom_range(0, 2);
      gap = idle_cycles(recv_mode);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
      @(negedge clk);
    end
  end

  // Predict on every accepted item, check every accepted result
  always @(posedge clk) begin : watch
    result_t r;
    result_t want;
    if (!rst && in_valid && !in_stall) begin
      r = advance_controller(kind, address, data, keyboard_data);
      pending_results.push_back(fixed_on ? fixed_result : r);
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with no item waiting");
      end else begin
        want = pending_results.pop_front();
        if (target !== want.target)
          flag_mismatch($sformatf("target %0d, want %0d", target, want.target));
        if (mem_offset !== want.mem_offset)
          flag_mismatch($sformatf("mem_offset %h, want %h", mem_offset, want.mem_offset));
        if (mem_write !== want.mem_write)
          flag_mismatch($sformatf("mem_write %b, want %b", mem_write, want.mem_write));
        if (io_data !== want.io_data)
          flag_mismatch($sformatf("io_data %h, want %h", io_data, want.io_data));
        if (irq_active !== want.irq_active)
          flag_mismatch($sformatf("irq_active %b, want %b", irq_active, want.irq_active));
        if (key_row_out !== want.key_row)
          flag_mismatch($sformatf("key_row_out %h, want %h", key_row_out, want.key_row));
      end
    end
  end

  initial begin : stimulus
    int         pick;
    logic [4:0] sel;
    logic [7:0] port;
    rst           = 1'b1;
    in_valid      = 1'b0;
    kind          = pmm_pkg::KIND_TICK;
    address       = '0;
    data          = '0;
    keyboard_data = '0;
    fixed_on      = 1'b0;
    fixed_result  = '0;
    mismatches    = 0;
    items_offered = 0;
    send_mode     = 0;
    page_sel      = '0;
    vram_cpu_bank = '0;
    vram_crtc_bank = '0;
    kbd_row       = '0;
    disp_mode     = '0;
    irq_pending   = 1'b0;
    tick_irq_en   = 1'b0;
    border_col    = '0;
    crtc_sel      = '0;
    for (int i = 0; i < 4; i++) pal_col[i] = '0;
    for (int i = 0; i < CRTC_REGS; i++) crtc_regs[i] = '0;

    // Reset state, map edges, suppressed ROM writes, interrupt path
    directed_rows.push_back(typed_row(pmm_pkg::KIND_MEM_RD, 16'h0000, 8'h00, 8'h00,
                                      pmm_pkg::TGT_SROM, 16'h0000, 1'b0,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'h0));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_MEM_WR, 16'h3FFF, 8'hFF, 8'h00,
                                      pmm_pkg::TGT_SROM, 16'h3FFF, 1'b0,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'h0));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_MEM_RD, 16'h4000, 8'h00, 8'h00,
                                      pmm_pkg::TGT_URAM, 16'h4000, 1'b0,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'h0));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_MEM_WR, 16'h8000, 8'h5A, 8'h00,
                                      pmm_pkg::TGT_VRAM, 16'h0000, 1'b1,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'h0));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_MEM_WR, 16'hFFFF, 8'hA5, 8'h00,
                                      pmm_pkg::TGT_CART, 16'h3FFF, 1'b1,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'h0));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_IO_RD, {8'h00, pmm_pkg::PORT_IRQ_ST_0},
                                      8'h00, 8'h00, pmm_pkg::TGT_NONE, 16'h0000, 1'b0,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'h0));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_IO_WR, {8'h00, pmm_pkg::PORT_IRQ_EN},
                                      8'h10, 8'h00, pmm_pkg::TGT_NONE, 16'h0000, 1'b0,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'h0));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_TICK, 16'h0000, 8'h00, 8'h00,
                                      pmm_pkg::TGT_NONE, 16'h0000, 1'b0,
                                      pmm_pkg::IO_IDLE, 1'b1, 4'h0));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_IO_RD, {8'hFF, pmm_pkg::PORT_IRQ_ST_1},
                                      8'h00, 8'h00, pmm_pkg::TGT_NONE, 16'h0000, 1'b0,
                                      pmm_pkg::IRQ_ST_SET, 1'b1, 4'h0));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_IO_WR, {8'h00, pmm_pkg::PORT_IRQ_ACK},
                                      8'h00, 8'h00, pmm_pkg::TGT_NONE, 16'h0000, 1'b0,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'h0));
    // All paging bits set: extension ROM on top, upper RAM at the bottom
    directed_rows.push_back(typed_row(pmm_pkg::KIND_IO_WR, {8'h00, pmm_pkg::PORT_PAGING},
                                      8'hFF, 8'h00, pmm_pkg::TGT_NONE, 16'h0000, 1'b0,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'h0));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_MEM_WR, 16'hC123, 8'h00, 8'h00,
                                      pmm_pkg::TGT_XROM, 16'h0123, 1'b0,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'h0));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_MEM_RD, 16'h0005, 8'h00, 8'h00,
                                      pmm_pkg::TGT_URAM, 16'hC005, 1'b0,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'h0));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_IO_WR, {8'h00, pmm_pkg::PORT_VBANK_0},
                                      8'h33, 8'h00, pmm_pkg::TGT_NONE, 16'h0000, 1'b0,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'h0));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_MEM_WR, 16'h7FFF, 8'h00, 8'h00,
                                      pmm_pkg::TGT_VRAM, 16'hFFFF, 1'b1,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'h0));
    // Keyboard row beyond the matrix, then a valid row
    directed_rows.push_back(typed_row(pmm_pkg::KIND_IO_WR, {8'h00, pmm_pkg::PORT_KEY_ROW},
                                      8'hFF, 8'h00, pmm_pkg::TGT_NONE, 16'h0000, 1'b0,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'hF));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_IO_RD, {8'h00, pmm_pkg::PORT_KBD_0},
                                      8'h00, 8'h00, pmm_pkg::TGT_NONE, 16'h0000, 1'b0,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'hF));
    directed_rows.push_back(open_row(pmm_pkg::KIND_IO_WR, {8'h00, pmm_pkg::PORT_KEY_ROW},
                                     8'h09, 8'h00));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_IO_RD, {8'h00, pmm_pkg::PORT_KBD_1},
                                      8'h00, 8'hA5, pmm_pkg::TGT_NONE, 16'h0000, 1'b0,
                                      8'hA5, 1'b0, 4'h9));
    // CRTC: top select ignores writes, masked write, read back
    directed_rows.push_back(open_row(pmm_pkg::KIND_IO_WR, {8'h00, pmm_pkg::PORT_CRTC_SEL},
                                     8'hFF, 8'h00));
    directed_rows.push_back(open_row(pmm_pkg::KIND_IO_WR, {8'h00, pmm_pkg::PORT_CRTC_DATA},
                                     8'hFF, 8'h00));
    directed_rows.push_back(open_row(pmm_pkg::KIND_IO_WR, {8'h00, pmm_pkg::PORT_CRTC_SEL},
                                     8'h0C, 8'h00));
    directed_rows.push_back(open_row(pmm_pkg::KIND_IO_WR, {8'h00, pmm_pkg::PORT_CRTC_DATA},
                                     8'hFF, 8'h00));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_IO_RD, {8'h00, pmm_pkg::PORT_CRTC_DATA},
                                      8'h00, 8'h00, pmm_pkg::TGT_NONE, 16'h0000, 1'b0,
                                      8'h3F, 1'b0, 4'h9));
    // Mode three, a palette entry, an unknown port and a spare kind
    directed_rows.push_back(open_row(pmm_pkg::KIND_IO_WR, {8'h00, pmm_pkg::PORT_MODE},
                                     8'h03, 8'h00));
    directed_rows.push_back(open_row(pmm_pkg::KIND_IO_WR, 16'h0063, 8'hFF, 8'h00));
    directed_rows.push_back(typed_row(pmm_pkg::KIND_IO_RD, 16'h0012, 8'h00, 8'h00,
                                      pmm_pkg::TGT_NONE, 16'h0000, 1'b0,
                                      pmm_pkg::IO_IDLE, 1'b0, 4'h9));
    directed_rows.push_back(open_row(KIND_SPARE, 16'hFFFF, 8'hFF, 8'hFF));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      offer_item(directed_rows[i].kind, directed_rows[i].address, directed_rows[i].data,
                 directed_rows[i].kbd, directed_rows[i].typed, directed_rows[i].want);

    // Random traffic: plain accesses, port sequences, ticks and noise
    while (items_offered < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        offer_item($urandom_range(0, 1) ? pmm_pkg::KIND_MEM_WR : pmm_pkg::KIND_MEM_RD,
                   16'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
      end else if (pick < 50) begin
        port = some_port();
        offer_item(pmm_pkg::KIND_IO_WR, {8'($urandom), port}, 8'($urandom), 8'($urandom),
                   1'b0, '0);
      end else if (pick < 60) begin
        port = some_port();
        offer_item(pmm_pkg::KIND_IO_RD, {8'($urandom), port}, 8'($urandom), 8'($urandom),
                   1'b0, '0);
      end else if (pick < 72) begin
        // select, write, read back data and select
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: sel = 5'($urandom_range(pmm_pkg::CRTC_RD_LOW, pmm_pkg::CRTC_RD_HIGH));
          5, 6, 7:       sel = 5'($urandom_range(0, pmm_pkg::CRTC_WR_LIMIT - 1));
          default:       sel = 5'($urandom);
        endcase
        offer_item(pmm_pkg::KIND_IO_WR, {8'($urandom), pmm_pkg::PORT_CRTC_SEL},
                   {3'($urandom), sel}, 8'($urandom), 1'b0, '0);
        offer_item(pmm_pkg::KIND_IO_WR, {8'($urandom), pmm_pkg::PORT_CRTC_DATA},
                   8'($urandom), 8'($urandom), 1'b0, '0);
        offer_item(pmm_pkg::KIND_IO_RD, {8'($urandom), pmm_pkg::PORT_CRTC_DATA},
                   8'($urandom), 8'($urandom), 1'b0, '0);
        offer_item(pmm_pkg::KIND_IO_RD, {8'($urandom), pmm_pkg::PORT_CRTC_SEL},
                   8'($urandom), 8'($urandom), 1'b0, '0);
      end else if (pick < 80) begin
        // enable, tick, read status, sometimes acknowledge
        offer_item(pmm_pkg::KIND_IO_WR, {8'($urandom), pmm_pkg::PORT_IRQ_EN},
                   8'($urandom) | ($urandom_range(0, 3) != 0 ? 8'h10 : 8'h00),
                   8'($urandom), 1'b0, '0);
        offer_item(pmm_pkg::KIND_TICK, 16'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
        offer_item(pmm_pkg::KIND_IO_RD,
                   {8'($urandom), $urandom_range(0, 1) ? pmm_pkg::PORT_IRQ_ST_0
                                                       : pmm_pkg::PORT_IRQ_ST_1},
                   8'($urandom), 8'($urandom), 1'b0, '0);
        if ($urandom_range(0, 1))
          offer_item(pmm_pkg::KIND_IO_WR, {8'($urandom), pmm_pkg::PORT_IRQ_ACK},
                     8'($urandom), 8'($urandom), 1'b0, '0);
      end else if (pick < 88) begin
        offer_item(pmm_pkg::KIND_TICK, 16'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
      end else if (pick < 92) begin
        offer_item(pmm_pkg::KIND_TICK + 3'($urandom_range(1, 3)), 16'($urandom),
                   8'($urandom), 8'($urandom), 1'b0, '0);
      end else begin
        offer_item(3'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
      end
    end

    // Drain the pipeline and give late strays a chance to show
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
